/* hw/rtl/tca_pkg.sv */
`default_nettype none
package tca_pkg;

  localparam int DIV_STEPS = 17;
  localparam int PRE_SHIFT = 13;
  localparam logic [63:0] EPS_Q44 = 64'd17592186;
  localparam logic [16:0] CMD_ONE = 17'd65536;

  typedef struct packed {
    logic lo;
    logic hi;
  } tca_flags_t;

endpackage
`default_nettype wire

/* hw/rtl/tca_div.sv */
`default_nettype none
module tca_div
  import tca_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire tca_flags_t  in_flags,
  input  wire logic [63:0] in_num,
  input  wire logic [63:0] in_den,
  output logic             out_valid,
  output tca_flags_t       out_flags,
  output logic [16:0]      out_quot
);

  logic [63:0] rem   [DIV_STEPS+1];
  logic [63:0] den   [DIV_STEPS+1];
  logic [16:0] quot  [DIV_STEPS+1];
  tca_flags_t  flags [DIV_STEPS+1];
  logic [DIV_STEPS:0] valid;
  logic [65:0] trial [DIV_STEPS];

  always_comb begin
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial[i] = {1'b0, rem[i], 1'b0} - {2'b00, den[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[DIV_STEPS-1:0], in_valid};
    end
    rem[0]   <= in_num << PRE_SHIFT;
    den[0]   <= in_den;
    quot[0]  <= '0;
    flags[0] <= in_flags;
    for (int i = 0; i < DIV_STEPS; i++) begin
      if (!trial[i][65]) begin
        rem[i+1]  <= trial[i][63:0];
        quot[i+1] <= {quot[i][15:0], 1'b1};
      end else begin
        rem[i+1]  <= {rem[i][62:0], 1'b0};
        quot[i+1] <= {quot[i][15:0], 1'b0};
      end
      den[i+1]   <= den[i];
      flags[i+1] <= flags[i];
    end
  end

  assign out_valid = valid[DIV_STEPS];
  assign out_flags = flags[DIV_STEPS];
  assign out_quot  = quot[DIV_STEPS];

endmodule
`default_nettype wire

/* hw/rtl/thruster_command_allocation.sv */
`default_nettype none
// channel | ports                                        | handshake
// input   | dir_*, pos_*, want_force_*, want_torque_*    | start && !busy
// result  | command, clamped_low, clamped_high           | done strobe
//
// one word enters per cycle; busy is always low
// start reaches done through the 17-step divider pipeline, which sits
// behind five multiply, sum and classification stages
// rst clears the valid bits only; payload registers are not reset
// the receiver cannot stall, so no stage ever holds
module thruster_command_allocation
  import tca_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] dir_x,
  input  wire logic signed [15:0] dir_y,
  input  wire logic signed [15:0] dir_z,
  input  wire logic signed [15:0] pos_x,
  input  wire logic signed [15:0] pos_y,
  input  wire logic signed [15:0] pos_z,
  input  wire logic signed [23:0] want_force_x,
  input  wire logic signed [23:0] want_force_y,
  input  wire logic signed [23:0] want_force_z,
  input  wire logic signed [23:0] want_torque_x,
  input  wire logic signed [23:0] want_torque_y,
  input  wire logic signed [23:0] want_torque_z,
  output logic                    done,
  output logic [16:0]             command,
  output logic                    clamped_low,
  output logic                    clamped_high
);

  logic signed [15:0] d_in [3];
  logic signed [15:0] p_in [3];
  logic signed [23:0] f_in [3];
  logic signed [23:0] t_in [3];

  assign d_in = '{dir_x, dir_y, dir_z};
  assign p_in = '{pos_x, pos_y, pos_z};
  assign f_in = '{want_force_x, want_force_y, want_force_z};
  assign t_in = '{want_torque_x, want_torque_y, want_torque_z};
  assign busy = 1'b0;

  // stage 1: direct products
  logic               s1_valid;
  logic signed [31:0] s1_a [3];
  logic signed [31:0] s1_b [3];
  logic signed [39:0] s1_df [3];
  logic signed [31:0] s1_dd [3];
  logic signed [23:0] s1_t [3];
  // stage 2: torque arm and partial sums
  logic               s2_valid;
  logic signed [32:0] s2_c [3];
  logic signed [41:0] s2_fsum;
  logic [33:0]        s2_dsum;
  logic signed [23:0] s2_t [3];
  // stage 3: arm products
  logic               s3_valid;
  logic signed [56:0] s3_ct [3];
  logic [63:0]        s3_cc [3];
  logic signed [41:0] s3_fsum;
  logic [33:0]        s3_dsum;
  // stage 4: numerator and denominator
  logic               s4_valid;
  logic signed [63:0] s4_num;
  logic [63:0]        s4_den;
  // stage 5: classification
  logic               s5_valid;
  tca_flags_t         s5_flags;
  logic [63:0]        s5_num;
  logic [63:0]        s5_den;

  logic signed [65:0] cc_full [3];
  logic signed [63:0] num_next;
  logic [63:0]        den_next;
  logic               pos_ratio;
  logic               over_one;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cc_full[k] = s2_c[k] * s2_c[k];
    end
    num_next = 64'(s3_fsum) <<< 8;
    den_next = ({30'd0, s3_dsum} << 16) + EPS_Q44;
    for (int k = 0; k < 3; k++) begin
      num_next = num_next + 64'(s3_ct[k]);
      den_next = den_next + s3_cc[k];
    end
    pos_ratio = !s4_num[63] && (s4_num != '0);
    over_one  = pos_ratio && (s4_num > signed'({14'd0, s4_den[63:14]}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else begin
      s1_valid <= start;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
    end
    s1_a[0] <= p_in[1] * d_in[2];
    s1_b[0] <= p_in[2] * d_in[1];
    s1_a[1] <= p_in[2] * d_in[0];
    s1_b[1] <= p_in[0] * d_in[2];
    s1_a[2] <= p_in[0] * d_in[1];
    s1_b[2] <= p_in[1] * d_in[0];
    for (int k = 0; k < 3; k++) begin
      s1_df[k] <= d_in[k] * f_in[k];
      s1_dd[k] <= d_in[k] * d_in[k];
      s1_t[k]  <= t_in[k];
      s2_c[k]  <= 33'(s1_a[k]) - 33'(s1_b[k]);
      s2_t[k]  <= s1_t[k];
      s3_ct[k] <= s2_c[k] * s2_t[k];
      s3_cc[k] <= cc_full[k][63:0];
    end
    s2_fsum <= 42'(s1_df[0]) + 42'(s1_df[1]) + 42'(s1_df[2]);
    s2_dsum <= {2'b00, s1_dd[0]} + {2'b00, s1_dd[1]} + {2'b00, s1_dd[2]};
    s3_fsum <= s2_fsum;
    s3_dsum <= s2_dsum;
    s4_num  <= num_next;
    s4_den  <= den_next;
    s5_flags.lo <= s4_num[63];
    s5_flags.hi <= over_one;
    s5_num  <= (pos_ratio && !over_one) ? s4_num : '0;
    s5_den  <= s4_den;
  end

  logic        dv_valid;
  tca_flags_t  dv_flags;
  logic [16:0] dv_quot;

  tca_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s5_valid),
    .in_flags (s5_flags),
    .in_num   (s5_num),
    .in_den   (s5_den),
    .out_valid(dv_valid),
    .out_flags(dv_flags),
    .out_quot (dv_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid;
    end
    clamped_low  <= dv_flags.lo;
    clamped_high <= dv_flags.hi;
    if (dv_flags.hi || dv_quot > CMD_ONE) begin
      command <= CMD_ONE;
    end else begin
      command <= dv_quot;
    end
  end

`ifndef SYNTHESIS
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(clamped_low && clamped_high)) else $error("both clamp flags set");
  a_high_full: assert property (@(posedge clk) disable iff (rst)
    (done && clamped_high) |-> (command == CMD_ONE)) else $error("high clamp not full");
  a_low_zero: assert property (@(posedge clk) disable iff (rst)
    (done && clamped_low) |-> (command == '0)) else $error("low clamp not zero");
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (command <= CMD_ONE)) else $error("command out of range");
`endif

endmodule
`default_nettype wire
